// ----- rtl/dbt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_pkg
// Widths and constants of the blanking timing calculator.
// ----------------------------------------------------------------------------
package dbt_pkg;

    localparam int XW       = 12;
    localparam int YW       = 12;
    localparam int FW       = 8;
    localparam int CLKW     = 24;
    localparam int OW       = 16;

    localparam int D_BASE   = 20000;
    localparam int F_COEF   = 11;
    localparam int F_COEF2  = 2 * F_COEF;
    localparam int H_SCALE  = 30;
    localparam int H_OFFS   = 300000;
    localparam int M_SCALE  = 70;
    localparam int CLK_DIV  = 1000;
    localparam int HS_DIV   = 100;
    localparam int HS_ROUND = 50;
    localparam int HS_STEP  = 8;
    localparam int VS_LEN   = 3;
    localparam logic [CLKW-1:0] CLK_MAX = '1;

    // divider chain sizes: numerator bits, divisor bits
    localparam int VNUM_W   = 28;
    localparam int VDEN_W   = 16;
    localparam int VBL_W    = 13;
    localparam int VW       = 21;
    localparam int HNUM_W   = 39;
    localparam int HDEN_W   = 32;
    localparam int HQ_W     = 16;
    localparam int CNUM_W   = 34;

    // floor(p/1000) = ((p >> 3) * CLK_RECIP) >> CLK_SHIFT, exact for p < 2^34
    localparam int CLK_PRE   = 3;
    localparam int CLK_SHIFT = 38;
    localparam int CRECIP_W  = 32;
    localparam logic [CRECIP_W-1:0] CLK_RECIP = 32'd2199023256;
    // floor(a/100) = (a * HS_RECIP) >> HS_SHIFT, exact for a < 43690
    localparam int HS_SHIFT  = 19;
    localparam int HRECIP_W  = 13;
    localparam logic [HRECIP_W-1:0] HS_RECIP = 13'd5243;

    localparam int LATENCY  = 10 + VNUM_W + HNUM_W;

endpackage

`default_nettype wire

// ----- rtl/dbt_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_div_cell
// One restoring-division step: shift in a numerator bit, try the subtract,
// shift the quotient bit in at the bottom, pass the item on.
// ----------------------------------------------------------------------------
module dbt_div_cell #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] nq_in,
    input  logic [DW-1:0] den_in,
    input  logic [PW-1:0] pay_in,
    output logic          valid_out,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] nq_out,
    output logic [DW-1:0] den_out,
    output logic [PW-1:0] pay_out
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] nq_reg, nq_next;
    logic [DW-1:0] den_reg;
    logic [PW-1:0] pay_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial    = {rem_in, nq_in[NW-1]};
        diff     = trial - {1'b0, den_in};
        ge       = trial >= {1'b0, den_in};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_next  = {nq_in[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_in;
        pay_reg <= pay_in;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign nq_out    = nq_reg;
    assign den_out   = den_reg;
    assign pay_out   = pay_reg;

endmodule

`default_nettype wire

// ----- rtl/dbt_div_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_div_chain
// Unsigned divider built as a row of NW step cells, one quotient bit each.
// ----------------------------------------------------------------------------
module dbt_div_chain #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    input  logic [PW-1:0] pay_in,
    output logic          valid_out,
    output logic [NW-1:0] quo_out,
    output logic [PW-1:0] pay_out
);

    logic          v_s   [NW+1];
    logic [DW-1:0] r_s   [NW+1];
    logic [NW-1:0] nq_s  [NW+1];
    logic [DW-1:0] d_s   [NW+1];
    logic [PW-1:0] p_s   [NW+1];

    assign v_s[0]  = valid_in;
    assign r_s[0]  = '0;
    assign nq_s[0] = num_in;
    assign d_s[0]  = den_in;
    assign p_s[0]  = pay_in;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        dbt_div_cell #(
            .NW (NW),
            .DW (DW),
            .PW (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (v_s[i]),
            .rem_in    (r_s[i]),
            .nq_in     (nq_s[i]),
            .den_in    (d_s[i]),
            .pay_in    (p_s[i]),
            .valid_out (v_s[i+1]),
            .rem_out   (r_s[i+1]),
            .nq_out    (nq_s[i+1]),
            .den_out   (d_s[i+1]),
            .pay_out   (p_s[i+1])
        );
    end

    assign valid_out = v_s[NW];
    assign quo_out   = nq_s[NW];
    assign pay_out   = p_s[NW];

endmodule

`default_nettype wire

// ----- rtl/display_blanking_timing_calc_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// display_blanking_timing_calc_top
// Simplified GTF-style modeline calculator in exact integer arithmetic.
// Built from the two divider chains (28 and 39 step cells) plus ten
// arithmetic stages.
// Throughput: one item per cycle; busy is always low, done is a one-cycle
// strobe and the receiver cannot stall.
// Reset clears every valid bit in the pipeline; data registers are not reset.
// ----------------------------------------------------------------------------
module display_blanking_timing_calc_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [dbt_pkg::XW-1:0]    width,
    input  logic [dbt_pkg::YW-1:0]    height,
    input  logic [dbt_pkg::FW-1:0]    refresh_hz,
    output logic                      done,
    output logic [dbt_pkg::CLKW-1:0]  pixel_clock_khz,
    output logic [dbt_pkg::OW-1:0]    hsync_start,
    output logic [dbt_pkg::OW-1:0]    hsync_end,
    output logic [dbt_pkg::OW-1:0]    hblank_end,
    output logic [dbt_pkg::OW-1:0]    vsync_start,
    output logic [dbt_pkg::OW-1:0]    vsync_end,
    output logic [dbt_pkg::OW-1:0]    vblank_end
);
    import dbt_pkg::*;

    localparam int P1W  = XW + YW + FW;
    localparam int P2W  = 1 + XW + YW + VBL_W + VW;
    localparam int CA_W = CNUM_W - CLK_PRE;
    localparam int CP_W = CA_W + CRECIP_W;
    localparam int SP_W = HS_SHIFT + OW;

    // stage A
    logic              va_reg;
    logic [14:0]       d_w;
    logic [13:0]       yy3_w;
    logic [12:0]       y1_w, f22_w;
    logic [VNUM_W-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [14:0]       da_reg;
    logic [P1W-1:0]    pa_reg;
    // stage B
    logic              vb_reg;
    logic [VNUM_W-1:0] vnum_reg;
    logic [VDEN_W-1:0] dv_reg;
    logic [P1W-1:0]    pb_reg;
    // chain 1
    logic              v1_w;
    logic [VNUM_W-1:0] q1_w;
    logic [P1W-1:0]    p1o_w;
    logic [XW-1:0]     x1_w;
    logic [YW-1:0]     y1o_w;
    logic [FW-1:0]     f1_w;
    // stage C
    logic              vc_reg;
    logic [VW-1:0]     vc_v_reg, vc_v_next;
    logic [VBL_W-1:0]  vc_vbl_reg;
    logic [XW-1:0]     vc_x_reg;
    logic [YW-1:0]     vc_y_reg;
    // stage D
    logic              vd_reg;
    logic [26:0]       t1_reg, t1_next;
    logic [30:0]       m_reg, m_next;
    logic [VW-1:0]     vd_v_reg;
    logic [VBL_W-1:0]  vd_vbl_reg;
    logic [XW-1:0]     vd_x_reg;
    logic [YW-1:0]     vd_y_reg;
    // stage E
    logic              ve_reg;
    logic signed [38:0] n_reg, n_next;
    logic [30:0]       me_reg;
    logic [VW-1:0]     ve_v_reg;
    logic [VBL_W-1:0]  ve_vbl_reg;
    logic [XW-1:0]     ve_x_reg;
    logic [YW-1:0]     ve_y_reg;
    // stage F
    logic              vf_reg;
    logic signed [39:0] num_w;
    logic [HNUM_W-1:0] mag_reg, mag_next;
    logic [HDEN_W-1:0] m2_reg;
    logic [P2W-1:0]    pf_reg, pf_next;
    // chain 2
    logic              v2_w;
    logic [HNUM_W-1:0] q2_w;
    logic [P2W-1:0]    p2o_w;
    logic              neg2_w;
    logic [XW-1:0]     x2_w;
    logic [YW-1:0]     y2_w;
    logic [VBL_W-1:0]  vbl2_w;
    logic [VW-1:0]     v2v_w;
    // stage G
    logic              vg_reg;
    logic signed [16:0] qs_w;
    logic [20:0]       hbl_w;
    logic [21:0]       s_reg, s_next;
    logic [OW-1:0]     hse_reg, hse_next, he_reg, he_next;
    logic [VW-1:0]     vg_v_reg;
    logic [VBL_W-1:0]  vg_vbl_reg;
    logic [YW-1:0]     vg_y_reg;
    // stage H
    logic              vh_reg;
    logic signed [43:0] prod_reg, prod_next;
    logic [21:0]       a_w;
    logic              neg100_reg;
    logic [20:0]       mag100_reg, mag100_next;
    logic [OW-1:0]     hh_hse_reg, hh_he_reg;
    logic [VBL_W-1:0]  vh_vbl_reg;
    logic [YW-1:0]     vh_y_reg;
    // stage I
    logic              vi_reg;
    logic              zero_reg, sat_reg, sat_w;
    logic [CP_W-1:0]   cprod_reg, cprod_next;
    logic [SP_W-1:0]   sprod_reg, sprod_next;
    logic              neg_i_reg;
    logic [OW-1:0]     hi_hse_reg, hi_he_reg;
    logic [YW-1:0]     vi_y_reg;
    logic [VBL_W-1:0]  vi_vbl_reg;
    // stage J
    logic [OW-1:0]     sq_w, q100_w;
    logic              done_reg;
    logic [CLKW-1:0]   clk_reg, clk_next;
    logic [OW-1:0]     hs_reg, hs_next, hend_reg, hbe_reg, vs_reg, vse_reg, vbe_reg;

    // stage A: line count numerator terms
    always_comb
    begin
        d_w     = 15'(D_BASE) - 15'(F_COEF * int'(refresh_hz));
        yy3_w   = {1'b0, height, 1'b0} + 14'd3;
        y1_w    = 13'(height) + 13'd1;
        f22_w   = 13'(F_COEF2 * int'(refresh_hz));
        p1_next = VNUM_W'(yy3_w) * VNUM_W'(d_w);
        p2_next = VNUM_W'(f22_w) * VNUM_W'(y1_w);
    end

    dbt_div_chain #(
        .NW (VNUM_W),
        .DW (VDEN_W),
        .PW (P1W)
    ) u_vdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (vb_reg),
        .num_in    (vnum_reg),
        .den_in    (dv_reg),
        .pay_in    (pb_reg),
        .valid_out (v1_w),
        .quo_out   (q1_w),
        .pay_out   (p1o_w)
    );

    assign {x1_w, y1o_w, f1_w} = p1o_w;

    // stages C to F: frame rate terms and blank numerator
    always_comb
    begin
        vc_v_next = VW'(q1_w[VBL_W-1:0]) * VW'(f1_w);
        t1_next   = 27'(vc_v_reg) * 27'(H_SCALE) - 27'(H_OFFS);
        m_next    = (31'(vc_v_reg) * 31'(M_SCALE) + 31'(H_OFFS)) << 4;
        n_next    = $signed({27'b0, vd_x_reg}) * $signed({{12{t1_reg[26]}}, t1_reg});
        num_w     = $signed({n_reg, 1'b0}) + $signed({9'b0, me_reg});
        mag_next  = num_w[39] ? HNUM_W'(-num_w) : num_w[HNUM_W-1:0];
        pf_next   = {num_w[39], ve_x_reg, ve_y_reg, ve_vbl_reg, ve_v_reg};
    end

    dbt_div_chain #(
        .NW (HNUM_W),
        .DW (HDEN_W),
        .PW (P2W)
    ) u_hdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (vf_reg),
        .num_in    (mag_reg),
        .den_in    (m2_reg),
        .pay_in    (pf_reg),
        .valid_out (v2_w),
        .quo_out   (q2_w),
        .pay_out   (p2o_w)
    );

    assign {neg2_w, x2_w, y2_w, vbl2_w, v2v_w} = p2o_w;

    // stages G and H: signed blank, line length, clock product
    always_comb
    begin
        qs_w        = neg2_w ? -$signed({1'b0, q2_w[HQ_W-1:0]})
                             :  $signed({1'b0, q2_w[HQ_W-1:0]});
        hbl_w       = {qs_w[16:0], 4'b0};
        s_next      = 22'(x2_w) + {hbl_w[20], hbl_w};
        hse_next    = OW'(x2_w) + {qs_w[12:0], 3'b0} - OW'(1);
        he_next     = s_next[OW-1:0] - OW'(1);
        prod_next   = $signed({{22{s_reg[21]}}, s_reg}) * $signed({23'b0, vg_v_reg});
        a_w         = s_reg + 22'(HS_ROUND);
        mag100_next = a_w[21] ? 21'(-a_w) : a_w[20:0];
    end

    // stage I: divide by the fixed constants through reciprocal multiplies
    always_comb
    begin
        sat_w      = !prod_reg[43] &&
                     (prod_reg[42:0] >= 43'((64'(CLK_MAX) + 64'd1) * 64'(CLK_DIV)));
        cprod_next = CP_W'(prod_reg[CNUM_W-1:CLK_PRE]) * CP_W'(CLK_RECIP);
        sprod_next = SP_W'(mag100_reg) * SP_W'(HS_RECIP);
    end

    // stage J: clamp the clock, finish sync start
    always_comb
    begin
        sq_w   = sprod_reg[HS_SHIFT +: OW];
        q100_w = neg_i_reg ? -sq_w : sq_w;
        if (zero_reg)
        begin
            clk_next = '0;
        end
        else if (sat_reg)
        begin
            clk_next = CLK_MAX;
        end
        else
        begin
            clk_next = cprod_reg[CLK_SHIFT +: CLKW];
        end
        hs_next = hi_hse_reg - OW'(q100_w * OW'(HS_STEP));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            vg_reg   <= 1'b0;
            vh_reg   <= 1'b0;
            vi_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= start;
            vb_reg   <= va_reg;
            vc_reg   <= v1_w;
            vd_reg   <= vc_reg;
            ve_reg   <= vd_reg;
            vf_reg   <= ve_reg;
            vg_reg   <= v2_w;
            vh_reg   <= vg_reg;
            vi_reg   <= vh_reg;
            done_reg <= vi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        da_reg     <= d_w;
        pa_reg     <= {width, height, refresh_hz};

        vnum_reg   <= p1_reg + p2_reg;
        dv_reg     <= {da_reg, 1'b0};
        pb_reg     <= pa_reg;

        vc_v_reg   <= vc_v_next;
        vc_vbl_reg <= q1_w[VBL_W-1:0];
        vc_x_reg   <= x1_w;
        vc_y_reg   <= y1o_w;

        t1_reg     <= t1_next;
        m_reg      <= m_next;
        vd_v_reg   <= vc_v_reg;
        vd_vbl_reg <= vc_vbl_reg;
        vd_x_reg   <= vc_x_reg;
        vd_y_reg   <= vc_y_reg;

        n_reg      <= n_next;
        me_reg     <= m_reg;
        ve_v_reg   <= vd_v_reg;
        ve_vbl_reg <= vd_vbl_reg;
        ve_x_reg   <= vd_x_reg;
        ve_y_reg   <= vd_y_reg;

        mag_reg    <= mag_next;
        m2_reg     <= {me_reg, 1'b0};
        pf_reg     <= pf_next;

        s_reg      <= s_next;
        hse_reg    <= hse_next;
        he_reg     <= he_next;
        vg_v_reg   <= v2v_w;
        vg_vbl_reg <= vbl2_w;
        vg_y_reg   <= y2_w;

        prod_reg   <= prod_next;
        neg100_reg <= a_w[21];
        mag100_reg <= mag100_next;
        hh_hse_reg <= hse_reg;
        hh_he_reg  <= he_reg;
        vh_vbl_reg <= vg_vbl_reg;
        vh_y_reg   <= vg_y_reg;

        // a negative product truncates to zero or below, so clamp it
        zero_reg   <= prod_reg[43];
        sat_reg    <= sat_w;
        cprod_reg  <= cprod_next;
        sprod_reg  <= sprod_next;
        neg_i_reg  <= neg100_reg;
        hi_hse_reg <= hh_hse_reg;
        hi_he_reg  <= hh_he_reg;
        vi_y_reg   <= vh_y_reg;
        vi_vbl_reg <= vh_vbl_reg;

        clk_reg    <= clk_next;
        hs_reg     <= hs_next;
        hend_reg   <= hi_hse_reg;
        hbe_reg    <= hi_he_reg;
        vs_reg     <= OW'(vi_y_reg);
        vse_reg    <= OW'(vi_y_reg) + OW'(VS_LEN);
        vbe_reg    <= OW'(vi_vbl_reg) - OW'(1);
    end

    assign busy            = 1'b0;
    assign done            = done_reg;
    assign pixel_clock_khz = clk_reg;
    assign hsync_start     = hs_reg;
    assign hsync_end       = hend_reg;
    assign hblank_end      = hbe_reg;
    assign vsync_start     = vs_reg;
    assign vsync_end       = vse_reg;
    assign vblank_end      = vbe_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("item did not complete at the fixed latency");

    a_vsync_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> vsync_end == vsync_start + OW'(VS_LEN))
        else $error("vertical sync length off");

    a_vblank_past_active: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> vblank_end >= vsync_start)
        else $error("total lines not above active lines");

    a_sat_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vi_reg |-> !(zero_reg && sat_reg))
        else $error("clock flagged both clamped and saturated");

endmodule

`default_nettype wire

// ----- tb/sv/display_blanking_timing_calc_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_blanking_timing_calc_top_tb
// Drives mode requests into the modeline calculator, predicts every timing
// field in exact integer arithmetic and compares each done strobe against
// the oldest pending modeline, under several sender idling patterns.
// ----------------------------------------------------------------------------
module display_blanking_timing_calc_top_tb;
    import dbt_pkg::*;

    typedef struct packed {
        logic [CLKW-1:0] pclk;
        logic [OW-1:0]   hs_start;
        logic [OW-1:0]   hs_end;
        logic [OW-1:0]   hb_end;
        logic [OW-1:0]   vs_start;
        logic [OW-1:0]   vs_end;
        logic [OW-1:0]   vb_end;
    } modeline_t;

    class modeline_board;
        modeline_t pending[$];
        int        mismatches = 0;

        function modeline_t calc_modeline(logic [XW-1:0] w, logic [YW-1:0] h,
                                          logic [FW-1:0] rate);
            longint x, y, f, d, vnum, vbl, v, n, m, hbl, pclk;
            modeline_t ml;
            x = longint'(w);
            y = longint'(h);
            f = longint'(rate);
            d = D_BASE - F_COEF * f;
            vnum = (2 * y + 3) * d + F_COEF2 * f * (y + 1);
            vbl = vnum / (2 * d);
            v = vbl * f;
            n = x * (H_SCALE * v - H_OFFS);
            m = 16 * (M_SCALE * v + H_OFFS);
            hbl = 16 * ((2 * n + m) / (2 * m));
            pclk = ((x + hbl) * v) / CLK_DIV;
            if (pclk < 0)
                pclk = 0;
            if (pclk > longint'(CLK_MAX))
                pclk = longint'(CLK_MAX);
            ml.pclk     = pclk[CLKW-1:0];
            ml.hs_start = OW'(x + hbl / 2 - ((x + hbl + HS_ROUND) / HS_DIV) * HS_STEP - 1);
            ml.hs_end   = OW'(x + hbl / 2 - 1);
            ml.hb_end   = OW'(x + hbl - 1);
            ml.vs_start = OW'(y);
            ml.vs_end   = OW'(y + VS_LEN);
            ml.vb_end   = OW'(vbl - 1);
            return ml;
        endfunction

        function void note_request(logic [XW-1:0] w, logic [YW-1:0] h,
                                   logic [FW-1:0] rate);
            pending.push_back(calc_modeline(w, h, rate));
        endfunction

        function void check_modeline(modeline_t got);
            modeline_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected modeline %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: pclk %0d/%0d hss %0d/%0d hse %0d/%0d hbe %0d/%0d",
                              " vss %0d/%0d vse %0d/%0d vbe %0d/%0d (exp/act)"},
                             want.pclk, got.pclk, want.hs_start, got.hs_start,
                             want.hs_end, got.hs_end, want.hb_end, got.hb_end,
                             want.vs_start, got.vs_start, want.vs_end, got.vs_end,
                             want.vb_end, got.vb_end);
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [XW-1:0]   width;
    logic [YW-1:0]   height;
    logic [FW-1:0]   refresh_hz;
    logic            done;
    logic [CLKW-1:0] pixel_clock_khz;
    logic [OW-1:0]   hsync_start;
    logic [OW-1:0]   hsync_end;
    logic [OW-1:0]   hblank_end;
    logic [OW-1:0]   vsync_start;
    logic [OW-1:0]   vsync_end;
    logic [OW-1:0]   vblank_end;

    modeline_board board = new();
    int            idle_pct;
    int            idle_pct_list[4] = '{0, 57, 0, 22};

    display_blanking_timing_calc_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .width           (width),
        .height          (height),
        .refresh_hz      (refresh_hz),
        .done            (done),
        .pixel_clock_khz (pixel_clock_khz),
        .hsync_start     (hsync_start),
        .hsync_end       (hsync_end),
        .hblank_end      (hblank_end),
        .vsync_start     (vsync_start),
        .vsync_end       (vsync_end),
        .vblank_end      (vblank_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // all inputs change by NBA, so this sees pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_request(width, height, refresh_hz);
        if (rst_n && done)
            board.check_modeline({pixel_clock_khz, hsync_start, hsync_end, hblank_end,
                                  vsync_start, vsync_end, vblank_end});
    end

    task automatic send_request(input logic [XW-1:0] w, input logic [YW-1:0] h,
                                input logic [FW-1:0] rate);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        width      <= w;
        height     <= h;
        refresh_hz <= rate;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [XW-1:0] w;
        logic [YW-1:0] h;
        logic [FW-1:0] rate;
        w    = XW'($urandom_range(1, 4095));
        h    = YW'($urandom_range(1, 4095));
        rate = FW'($urandom_range(1, 240));
        case ($urandom_range(9))
            0: w = XW'($urandom);
            1: h = YW'($urandom);
            2: rate = FW'($urandom);
            3: rate = FW'($urandom_range(30, 120));
            default: ;
        endcase
        send_request(w, h, rate);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        width      = '0;
        height     = '0;
        refresh_hz = '0;
        idle_pct   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(1, 1, 1);
        send_request(4095, 4095, 240);
        send_request(0, 0, 0);
        send_request(4095, 4095, 255);
        send_request(0, 4095, 255);
        send_request(4095, 0, 0);
        send_request(4095, 1, 0);
        send_request(1, 4095, 1);
        send_request(4095, 1, 255);
        send_request(1, 1, 255);
        send_request(1920, 1080, 60);
        send_request(640, 480, 60);
        send_request(800, 600, 75);
        send_request(1024, 768, 0);
        send_request(2048, 2048, 128);
        send_request(2730, 1365, 170);
        send_request(1365, 2730, 85);
        send_request(16, 16, 241);
        send_request(3840, 2160, 30);
        send_request(4095, 4095, 1);

        // hold off until the pipeline is empty
        drain();

        foreach (idle_pct_list[i])
        begin
            idle_pct = idle_pct_list[i];
            repeat (325) send_random();
        end

        drain();
        repeat (150) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("display_blanking_timing_calc_top_tb OK");
        else
            $display("display_blanking_timing_calc_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("display_blanking_timing_calc_top_tb NOT OK");
        $finish;
    end

endmodule
